@@ hw/rtl/mcs_pkg.sv @@
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared widths, codes and the controller-to-datapath command struct.
// ----------------------------------------------------------------------------
package mcs_pkg;

  localparam int SAMPLE_W = 17;            // signed sample width
  localparam int DIFF_W   = SAMPLE_W + 1;  // signed difference width
  localparam int RANGE_W  = SAMPLE_W;      // unsigned range width
  localparam int NUM_W    = RANGE_W + 9;   // diff * 255 plus headroom
  localparam int PIX_W    = 8;
  localparam int LANES    = 3;
  localparam int BIT_W    = 3;             // index of quotient bit

  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_SCALE   = 1'b1;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [PIX_W-1:0]           pixel_t;

  typedef struct packed {
    logic             meas_en;     // update min/max from the input item
    logic             scale_load;  // latch the scale item into the lanes
    logic             div_step;    // one restoring division step
    logic [BIT_W-1:0] bit_idx;     // quotient bit resolved by this step
    logic             out_load;    // move results into the output register
  } dp_cmd_t;

endpackage

@@ hw/rtl/mcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// mcs_ctrl
// Sequencer: accepts items, runs the eight division steps, loads the output.
// ----------------------------------------------------------------------------
module mcs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_cmd,
  output logic            in_stall,
  input  logic            out_stall,
  output logic            out_valid,
  output mcs_pkg::dp_cmd_t dp_cmd
);
  import mcs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [BIT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic             out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    dp_cmd         = '0;
    dp_cmd.bit_idx = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_SCALE) begin
            dp_cmd.scale_load = 1'b1;
            cnt_nxt           = '1;
            state_nxt         = ST_DIV;
          end else begin
            dp_cmd.meas_en = 1'b1;
          end
        end
      end
      ST_DIV: begin
        dp_cmd.div_step = 1'b1;
        cnt_nxt         = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          dp_cmd.out_load = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (dp_cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hw/rtl/mcs_dp.sv @@
// ----------------------------------------------------------------------------
// mcs_dp
// Datapath: min/max tracking, range setup and three restoring divider lanes.
// ----------------------------------------------------------------------------
module mcs_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_rgb,
  input  mcs_pkg::dp_cmd_t dp_cmd,
  input  logic             in_frame_start,
  input  mcs_pkg::sample_t in_sample_a,
  input  mcs_pkg::sample_t in_sample_g,
  input  mcs_pkg::sample_t in_sample_b,
  output mcs_pkg::pixel_t  out_pixel_a,
  output mcs_pkg::pixel_t  out_pixel_g,
  output mcs_pkg::pixel_t  out_pixel_b
);
  import mcs_pkg::*;

  logic                rgb_mode_r;
  sample_t             min_r, max_r;
  logic                awaiting_r;
  logic [RANGE_W-1:0]  range_r;
  logic [NUM_W-1:0]    num_r  [LANES];
  logic [PIX_W-1:0]    quo_r  [LANES];
  logic                zero_r [LANES];
  logic                sat_r  [LANES];
  pixel_t              pix_r  [LANES];

  sample_t             samp [LANES];
  sample_t             lo, hi;
  logic [DIFF_W-1:0]   rdiff;
  logic [RANGE_W-1:0]  range_w;
  logic [DIFF_W-1:0]   diff   [LANES];
  logic                zero_w [LANES];
  logic                sat_w  [LANES];
  logic [NUM_W-1:0]    num_w  [LANES];
  logic [NUM_W-1:0]    shifted;
  logic [NUM_W:0]      trial  [LANES];

  assign samp[0] = in_sample_a;
  assign samp[1] = in_sample_g;
  assign samp[2] = in_sample_b;

  // combined extremes of the item; green and blue count only in RGB mode
  always_comb begin
    lo = in_sample_a;
    hi = in_sample_a;
    if (rgb_mode_r) begin
      if (in_sample_g < lo) lo = in_sample_g;
      if (in_sample_b < lo) lo = in_sample_b;
      if (in_sample_g > hi) hi = in_sample_g;
      if (in_sample_b > hi) hi = in_sample_b;
    end
  end

  // range = max - min, a zero or negative range acts as 1
  always_comb begin
    rdiff = {max_r[SAMPLE_W-1], max_r} - {min_r[SAMPLE_W-1], min_r};
    if (rdiff[DIFF_W-1] || rdiff == '0) begin
      range_w = RANGE_W'(1);
    end else begin
      range_w = rdiff[RANGE_W-1:0];
    end
  end

  // diff >= range saturates, so only quotients below 255 go through the divider
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      diff[i]   = {samp[i][SAMPLE_W-1], samp[i]} - {min_r[SAMPLE_W-1], min_r};
      zero_w[i] = diff[i][DIFF_W-1] || diff[i] == '0;
      sat_w[i]  = !zero_w[i] && (diff[i][RANGE_W-1:0] >= range_w);
      num_w[i]  = {1'b0, diff[i][RANGE_W-1:0], 8'd0}
                - {9'd0, diff[i][RANGE_W-1:0]};
    end
  end

  assign shifted = {9'd0, range_r} << dp_cmd.bit_idx;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      trial[i] = {1'b0, num_r[i]} - {1'b0, shifted};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rgb_mode_r <= 1'b0;
      min_r      <= '0;
      max_r      <= '0;
      awaiting_r <= 1'b1;
    end else begin
      if (cfg_we) begin
        rgb_mode_r <= cfg_rgb;
      end
      if (dp_cmd.meas_en) begin
        awaiting_r <= 1'b0;
        if (in_frame_start || awaiting_r) begin
          min_r <= lo;
          max_r <= hi;
        end else begin
          if (lo < min_r) min_r <= lo;
          if (hi > max_r) max_r <= hi;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.scale_load) begin
      range_r <= range_w;
    end
    for (int i = 0; i < LANES; i++) begin
      if (dp_cmd.scale_load) begin
        num_r[i]  <= num_w[i];
        quo_r[i]  <= '0;
        zero_r[i] <= zero_w[i];
        sat_r[i]  <= sat_w[i];
      end else if (dp_cmd.div_step && !trial[i][NUM_W]) begin
        num_r[i]                 <= trial[i][NUM_W-1:0];
        quo_r[i][dp_cmd.bit_idx] <= 1'b1;
      end
      if (dp_cmd.out_load) begin
        if (zero_r[i] || (i != 0 && !rgb_mode_r)) begin
          pix_r[i] <= '0;
        end else if (sat_r[i]) begin
          pix_r[i] <= PIX_MAX;
        end else begin
          pix_r[i] <= quo_r[i];
        end
      end
    end
  end

  assign out_pixel_a = pix_r[0];
  assign out_pixel_g = pix_r[1];
  assign out_pixel_b = pix_r[2];

endmodule

@@ hw/rtl/minmax_contrast_stretch_core.sv @@
// ----------------------------------------------------------------------------
// minmax_contrast_stretch_core
// Two-pass min-max contrast stretch of integer samples to 8-bit pixels.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------
//  in      | in_valid/in_stall  | in_cmd, in_frame_start, in_sample_a/g/b
//  out     | out_valid/out_stall| out_pixel_a, out_pixel_g, out_pixel_b
//  cfg     | cfg_valid/cfg_ready| cfg_data (rgb_mode)
//
//  A measure item leaves the input free. A scale item stalls the input while the
//  restoring divider runs, one quotient bit per cycle, all three lanes at once.
//  A finished result sits in the output register while the next item enters.
//  Synchronous active-low reset clears the extremes, rgb_mode and the handshake.
//  out_stall only holds the output register; a result waiting in the divider
//  keeps in_stall high until the output register frees.
// ----------------------------------------------------------------------------
module minmax_contrast_stretch_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_cmd,
  input  logic             in_frame_start,
  input  mcs_pkg::sample_t in_sample_a,
  input  mcs_pkg::sample_t in_sample_g,
  input  mcs_pkg::sample_t in_sample_b,
  output logic             out_valid,
  input  logic             out_stall,
  output mcs_pkg::pixel_t  out_pixel_a,
  output mcs_pkg::pixel_t  out_pixel_g,
  output mcs_pkg::pixel_t  out_pixel_b,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data
);
  import mcs_pkg::*;

  dp_cmd_t dp_cmd;

  assign cfg_ready = 1'b1;

  mcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .dp_cmd    (dp_cmd)
  );

  mcs_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_rgb        (cfg_data),
    .dp_cmd         (dp_cmd),
    .in_frame_start (in_frame_start),
    .in_sample_a    (in_sample_a),
    .in_sample_g    (in_sample_g),
    .in_sample_b    (in_sample_b),
    .out_pixel_a    (out_pixel_a),
    .out_pixel_g    (out_pixel_g),
    .out_pixel_b    (out_pixel_b)
  );

endmodule

@@ hw/rtl/mcs_checker.sv @@
// ----------------------------------------------------------------------------
// mcs_checker
// Port-level checks on the contrast stretch core, bound to the top level.
// ----------------------------------------------------------------------------
module mcs_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic in_cmd,
  input logic out_valid,
  input logic out_stall
);
  import mcs_pkg::*;

  logic acc;
  assign acc = in_valid && !in_stall;

  // a result held by the receiver stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // a scale item occupies the divider on the next cycle
  a_scale_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_cmd == CMD_SCALE |=> in_stall)
    else $error("input not stalled after scale item");

  // a measure item leaves the input free on the next cycle
  a_meas_free: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_cmd == CMD_MEASURE |=> !in_stall)
    else $error("input stalled after measure item");

  // a scale item is not followed straight away by a new result
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_cmd == CMD_SCALE |=> !$rose(out_valid))
    else $error("result appeared right after scale item");

endmodule

bind minmax_contrast_stretch_core mcs_checker u_mcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_cmd    (in_cmd),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
